// ----- rtl/core/pol_pkg.sv -----
// Shared types and codes for the positional ordered list.
// No dependencies; the list module and the testbench import this package (pol_ram does not).
package pol_pkg;

  typedef logic [2:0] op_t;
  typedef logic [1:0] status_t;

  // Operation codes carried on the op field.
  localparam op_t OP_INSERT = 3'd0;
  localparam op_t OP_APPEND = 3'd1;
  localparam op_t OP_DELETE = 3'd2;
  localparam op_t OP_FIND   = 3'd3;
  localparam op_t OP_SEARCH = 3'd4;
  localparam op_t OP_CLEAR  = 3'd5;

  // Result status codes.
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

// ----- rtl/core/positional_ordered_list.sv -----
// Positional ordered list: an ordered sequence of up to CAPACITY words kept in one
// synchronous RAM, with insert-after-position, append, delete, find, search and clear.
// Depends on pol_pkg and pol_ram.
//
// One word is taken at a time and gives exactly one result word. An insert shifts the
// entries after its position up by one slot (none move for an append), a delete
// reads the addressed entry and pulls the tail down, a find reads the addressed entry,
// and a search compares entries from the head until a hit or the end; clear, an unused
// op code, a search of an empty list and any rejected request need no RAM walk.
// The pace is set by the single RAM: each shift or compare step moves one entry per
// cycle through its one read and one write port, pipelined so that a read and the
// write-back of the previous entry overlap.
// The list memory is not cleared at reset; only entries below the length are read.
// A finished result waits in an output register, so the next word is accepted as soon
// as the sequencer is free, even while the previous result is still stalled.
module positional_ordered_list #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pol_pkg::op_t     in_op,
  input  logic [6:0]       in_position,
  input  logic [31:0]      in_value,
  output logic             out_valid,
  input  logic             out_stall,
  output pol_pkg::status_t out_status,
  output logic [31:0]      out_value_out,
  output logic [6:0]       out_index_out,
  output logic [6:0]       out_length_out
);

  import pol_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 7) ? CW : 7;
  localparam int XW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  // Control registers.
  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          go_r, go_nxt;
  logic          wb_vld_r, wb_vld_nxt;
  logic          cap_r, cap_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [AW-1:0]         end_r, end_nxt;
  logic [AW-1:0]         k_r, k_nxt;
  logic [AW-1:0]         wb_addr_r, wb_addr_nxt;
  logic [DATA_WIDTH-1:0] v_r, v_nxt;
  logic                  is_del_r, is_del_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [31:0]           res_value_r, res_value_nxt;
  logic [6:0]            res_index_r, res_index_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [31:0]           out_value_r, out_value_nxt;
  logic [6:0]            out_index_r, out_index_nxt;
  logic [6:0]            out_length_r, out_length_nxt;

  // RAM port signals.
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  // Helper values.
  logic                  accept;
  logic                  out_free;
  logic [PW-1:0]         pos_x;
  logic [PW-1:0]         cnt_x;
  logic [PW-1:0]         pos_m1;
  logic [CW-1:0]         cnt_m1;
  logic [XW-1:0]         val_x;
  logic [XW-1:0]         rd_x;
  logic [CW-1:0]         hit_idx;
  logic [PW-1:0]         hit_idx_x;
  logic                  full;

  pol_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign pos_x     = PW'(in_position);
  assign cnt_x     = PW'(count_r);
  assign pos_m1    = pos_x - PW'(1);
  assign cnt_m1    = count_r - CW'(1);
  assign val_x     = XW'(in_value);
  assign rd_x      = XW'(mem_rdata);
  assign hit_idx   = CW'(wb_addr_r) + CW'(1);
  assign hit_idx_x = PW'(hit_idx);
  assign full      = (count_r == CW'(CAPACITY));

  // Sequencer: decodes a request, then walks the RAM one entry per cycle where the operation needs it.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    go_nxt         = go_r;
    wb_vld_nxt     = wb_vld_r;
    cap_nxt        = cap_r;
    ptr_nxt        = ptr_r;
    end_nxt        = end_r;
    k_nxt          = k_r;
    wb_addr_nxt    = wb_addr_r;
    v_nxt          = v_r;
    is_del_nxt     = is_del_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_index_nxt  = res_index_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_index_nxt  = out_index_r;
    out_length_nxt = out_length_r;
    mem_we         = 1'b0;
    mem_waddr      = wb_addr_r;
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = ptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          v_nxt          = val_x[DATA_WIDTH-1:0];
          res_status_nxt = ST_OK;
          res_value_nxt  = '0;
          res_index_nxt  = '0;
          go_nxt         = 1'b0;
          wb_vld_nxt     = 1'b0;
          cap_nxt        = 1'b0;
          is_del_nxt     = 1'b0;
          state_nxt      = S_RESP;
          unique case (in_op)
            OP_INSERT, OP_APPEND: begin
              if ((in_op == OP_INSERT) && (pos_x > cnt_x)) begin
                res_status_nxt = ST_RANGE;
              end else if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                // Shift entries k..n-1 up by one, from the top down.
                k_nxt     = (in_op == OP_INSERT) ? pos_x[AW-1:0] : count_r[AW-1:0];
                ptr_nxt   = cnt_m1[AW-1:0];
                go_nxt    = (in_op == OP_INSERT) ? (pos_x < cnt_x) : 1'b0;
                state_nxt = S_INS;
              end
            end
            OP_DELETE, OP_FIND: begin
              if ((pos_x == '0) || (pos_x > cnt_x)) begin
                res_status_nxt = ST_RANGE;
              end else begin
                // Read the addressed word, then pull the tail down for a delete.
                k_nxt      = pos_m1[AW-1:0];
                ptr_nxt    = pos_m1[AW-1:0];
                end_nxt    = (in_op == OP_DELETE) ? cnt_m1[AW-1:0] : pos_m1[AW-1:0];
                is_del_nxt = (in_op == OP_DELETE);
                go_nxt     = 1'b1;
                state_nxt  = S_DEL;
              end
            end
            OP_SEARCH: begin
              if (count_r != '0) begin
                ptr_nxt   = '0;
                end_nxt   = cnt_m1[AW-1:0];
                go_nxt    = 1'b1;
                state_nxt = S_SRCH;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_INS: begin
        // Write back the word read last cycle one slot higher.
        if (wb_vld_r) begin
          mem_we = 1'b1;
        end
        if (go_r) begin
          mem_re      = 1'b1;
          wb_vld_nxt  = 1'b1;
          wb_addr_nxt = ptr_r + AW'(1);
          if (ptr_r == k_r) begin
            go_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r - AW'(1);
          end
        end else begin
          wb_vld_nxt = 1'b0;
          if (!wb_vld_r) begin
            // The gap is open: place the new word.
            mem_we    = 1'b1;
            mem_waddr = k_r;
            mem_wdata = v_r;
            count_nxt = count_r + CW'(1);
            state_nxt = S_RESP;
          end
        end
      end

      S_DEL: begin
        // The first read returns the addressed word; later reads move down one slot.
        if (cap_r) begin
          res_value_nxt = rd_x[31:0];
        end
        if (wb_vld_r) begin
          mem_we = 1'b1;
        end
        if (go_r) begin
          mem_re = 1'b1;
          if (ptr_r == k_r) begin
            cap_nxt    = 1'b1;
            wb_vld_nxt = 1'b0;
          end else begin
            cap_nxt     = 1'b0;
            wb_vld_nxt  = 1'b1;
            wb_addr_nxt = ptr_r - AW'(1);
          end
          if (ptr_r == end_r) begin
            go_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + AW'(1);
          end
        end else begin
          cap_nxt    = 1'b0;
          wb_vld_nxt = 1'b0;
          if (!wb_vld_r && !cap_r) begin
            if (is_del_r) begin
              count_nxt = count_r - CW'(1);
            end
            state_nxt = S_RESP;
          end
        end
      end

      S_SRCH: begin
        // wb_vld_r marks a read in flight and wb_addr_r holds its slot.
        if (wb_vld_r && (mem_rdata == v_r)) begin
          res_index_nxt = hit_idx_x[6:0];
          wb_vld_nxt    = 1'b0;
          go_nxt        = 1'b0;
          state_nxt     = S_RESP;
        end else if (go_r) begin
          mem_re      = 1'b1;
          wb_vld_nxt  = 1'b1;
          wb_addr_nxt = ptr_r;
          if (ptr_r == end_r) begin
            go_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + AW'(1);
          end
        end else begin
          wb_vld_nxt = 1'b0;
          state_nxt  = S_RESP;
        end
      end

      S_RESP: begin
        // Hand the result to the output register once it is free.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_index_nxt  = res_index_r;
          out_length_nxt = cnt_x[6:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      go_r        <= 1'b0;
      wb_vld_r    <= 1'b0;
      cap_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      go_r        <= go_nxt;
      wb_vld_r    <= wb_vld_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    end_r        <= end_nxt;
    k_r          <= k_nxt;
    wb_addr_r    <= wb_addr_nxt;
    v_r          <= v_nxt;
    is_del_r     <= is_del_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_index_r  <= res_index_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_index_r  <= out_index_nxt;
    out_length_r <= out_length_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_value_out  = out_value_r;
  assign out_index_out  = out_index_r;
  assign out_length_out = out_length_r;

  // The length never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("list length above capacity");

  // The length moves by at most one per cycle, or drops to zero on a clear.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)) ||
    (count_r == $past(count_r) - CW'(1)) || (count_r == '0))
    else $error("list length jumped");

  // The RAM is never written while the sequencer is idle or holding a result.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) || (state_r == S_RESP)) |-> !mem_we)
    else $error("RAM write outside an operation");

  // An accepted word always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted word not processed");

endmodule

// ----- rtl/core/pol_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds while no read is issued. No dependencies.
module pol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- bench/positional_ordered_list_test.sv -----
// Testbench for the positional ordered list: a short directed sequence, then random words.
// Results are checked against fixed answers or a behavioral list copy kept in this file.
// Depends on pol_pkg and the positional_ordered_list RTL.
module positional_ordered_list_test;
  import pol_pkg::*;

  localparam int CAPACITY       = 64;
  localparam int RANDOM_WORDS   = 1350;
  localparam int NUM_DIRECTED   = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 150;
  localparam int REPORT_LIMIT   = 10;

  // The two op codes that the block accepts but does nothing with.
  localparam op_t OP_SPARE6 = 3'd6;
  localparam op_t OP_SPARE7 = 3'd7;

  // Data words that recur, so that searches hit and duplicates appear.
  localparam logic [5:0][31:0] VALUE_POOL = {
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h8000_0000, 32'h5A5A_5A5A, 32'hA5A5_A5A5
  };

  typedef struct packed {
    status_t     status;
    logic [31:0] value_out;
    logic [6:0]  index_out;
    logic [6:0]  length_out;
  } list_result_t;

  typedef struct packed {
    op_t          op;
    logic [6:0]   position;
    logic [31:0]  value;
    logic         has_answer;
    list_result_t answer;
  } directed_row_t;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} op_mix_t;

  localparam list_result_t NO_ANSWER = '0;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  op_t         in_op       = OP_INSERT;
  logic [6:0]  in_position = 7'd0;
  logic [31:0] in_value    = 32'd0;
  logic        out_stall   = 1'b0;
  logic        in_stall;
  logic        out_valid;
  status_t     out_status;
  logic [31:0] out_value_out;
  logic [6:0]  out_index_out;
  logic [6:0]  out_length_out;

  // Behavioral copy of the list contents and length.
  logic [31:0] list_words [CAPACITY];
  int          list_len = 0;

  list_result_t  pending_results [$];
  directed_row_t directed_rows [NUM_DIRECTED];

  int send_idle_pct = 13;
  int recv_idle_pct = 81;
  int fail_count    = 0;
  int quiet_cycles  = 0;

  positional_ordered_list i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_value_out  (out_value_out),
    .out_index_out  (out_index_out),
    .out_length_out (out_length_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Insert v so that it lands at 0-based slot k; the range check precedes the full check.
  function automatic status_t place_word(int k, logic [31:0] v);
    if (k > list_len) return ST_RANGE;
    if (list_len >= CAPACITY) return ST_FULL;
    for (int i = list_len; i > k; i--) list_words[i] = list_words[i - 1];
    list_words[k] = v;
    list_len++;
    return ST_OK;
  endfunction

  // Apply one request to the list copy and return the result word it should produce.
  function automatic list_result_t apply_request(op_t op, logic [6:0] position,
                                                 logic [31:0] value);
    list_result_t res;
    int k;
    res = '0;
    k = int'(position);
    case (op)
      OP_INSERT: res.status = place_word(k, value);
      OP_APPEND: res.status = place_word(list_len, value);
      OP_DELETE, OP_FIND: begin
        if (k < 1 || k > list_len) begin
          res.status = ST_RANGE;
        end else begin
          res.value_out = list_words[k - 1];
          if (op == OP_DELETE) begin
            for (int i = k - 1; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
            list_len--;
          end
        end
      end
      OP_SEARCH: begin
        for (int i = list_len - 1; i >= 0; i--) begin
          if (list_words[i] == value) res.index_out = 7'(i + 1);
        end
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    res.length_out = 7'(list_len);
    return res;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  // Offer one word after a random gap and hold it until accepted; predict at acceptance.
  task automatic send_word(op_t op, logic [6:0] position, logic [31:0] value,
                           output list_result_t predicted);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_position <= position;
    in_value    <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = apply_request(op, position, value);
  endtask

  // Hold the input side off until every outstanding result word has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Draw a random request; the mix sets which operations dominate the current stretch.
  task automatic pick_random_word(op_mix_t mix, output op_t op, output logic [6:0] position,
                                  output logic [31:0] value);
    int roll;
    int pick;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:
        op = roll < 45 ? OP_INSERT : roll < 75 ? OP_APPEND : roll < 83 ? OP_SEARCH :
             roll < 91 ? OP_FIND : roll < 97 ? OP_DELETE : OP_SPARE6;
      MIX_SHRINK:
        op = roll < 48 ? OP_DELETE : roll < 63 ? OP_FIND : roll < 78 ? OP_SEARCH :
             roll < 88 ? OP_INSERT : roll < 95 ? OP_APPEND : roll < 98 ? OP_CLEAR : OP_SPARE6;
      default:
        op = roll < 22 ? OP_INSERT : roll < 36 ? OP_APPEND : roll < 58 ? OP_DELETE :
             roll < 74 ? OP_FIND : roll < 95 ? OP_SEARCH : roll < 98 ? OP_CLEAR : OP_SPARE6;
    endcase
    if (op == OP_SPARE6 && $urandom_range(0, 1) == 1) op = OP_SPARE7;

    // Mostly near the live range, sometimes anywhere, sometimes right on an edge.
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      position = 7'($urandom_range(0, list_len + 1));
    end else if (pick < 88) begin
      position = 7'($urandom_range(0, 127));
    end else begin
      case ($urandom_range(0, 3))
        0: position = 7'd0;
        1: position = 7'd1;
        2: position = 7'(list_len);
        default: position = 7'(list_len + 1);
      endcase
    end

    pick = $urandom_range(0, 99);
    if (op == OP_SEARCH && list_len > 0 && pick < 50) begin
      value = list_words[$urandom_range(0, list_len - 1)];
    end else if (pick < 70) begin
      value = VALUE_POOL[$urandom_range(0, 5)];
    end else begin
      value = $urandom;
    end
  endtask

  // Check each accepted result word against the oldest prediction, and drive random stalls.
  always @(posedge clk) begin : result_check
    list_result_t got;
    list_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.status     = out_status;
      got.value_out  = out_value_out;
      got.index_out  = out_index_out;
      got.length_out = out_length_out;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result word: status %0d value %h index %0d length %0d",
                               got.status, got.value_out, got.index_out, got.length_out));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          note_failure($sformatf({"mismatch: expected status %0d value %h index %0d length %0d,",
                                  " got status %0d value %h index %0d length %0d"},
                                 want.status, want.value_out, want.index_out, want.length_out,
                                 got.status, got.value_out, got.index_out, got.length_out));
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // End the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("positional_ordered_list_test: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    list_result_t predicted;
    op_t          op;
    logic [6:0]   position;
    logic [31:0]  value;
    op_mix_t      mix;
    int           mix_left;

    // Directed sequence: empty-list errors, both extremes of the data word, every op,
    // the bad insert position, bad delete and find positions, and the unused op codes.
    directed_rows = '{
      '{OP_FIND,   7'd1,   32'h0,         1'b1, '{ST_RANGE, 32'h0, 7'd0, 7'd0}},
      '{OP_DELETE, 7'd0,   32'h0,         1'b1, '{ST_RANGE, 32'h0, 7'd0, 7'd0}},
      '{OP_SEARCH, 7'd0,   32'h0,         1'b1, '{ST_OK,    32'h0, 7'd0, 7'd0}},
      '{OP_INSERT, 7'd1,   32'hDEAD_BEEF, 1'b1, '{ST_RANGE, 32'h0, 7'd0, 7'd0}},
      '{OP_INSERT, 7'd0,   32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h0, 7'd0, 7'd1}},
      '{OP_APPEND, 7'd127, 32'h0,         1'b1, '{ST_OK,    32'h0, 7'd0, 7'd2}},
      '{OP_INSERT, 7'd2,   32'h1234_5678, 1'b0, NO_ANSWER},
      '{OP_INSERT, 7'd1,   32'hA5A5_A5A5, 1'b0, NO_ANSWER},
      '{OP_FIND,   7'd4,   32'h0,         1'b0, NO_ANSWER},
      '{OP_FIND,   7'd5,   32'h0,         1'b1, '{ST_RANGE, 32'h0, 7'd0, 7'd4}},
      '{OP_SEARCH, 7'd0,   32'hFFFF_FFFF, 1'b0, NO_ANSWER},
      '{OP_SEARCH, 7'd0,   32'h5A5A_5A5A, 1'b0, NO_ANSWER},
      '{OP_DELETE, 7'd1,   32'h0,         1'b0, NO_ANSWER},
      '{OP_DELETE, 7'd3,   32'h0,         1'b0, NO_ANSWER},
      '{OP_FIND,   7'd0,   32'h0,         1'b1, '{ST_RANGE, 32'h0, 7'd0, 7'd2}},
      '{OP_SPARE6, 7'd127, 32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h0, 7'd0, 7'd2}},
      '{OP_SPARE7, 7'd0,   32'h0,         1'b1, '{ST_OK,    32'h0, 7'd0, 7'd2}},
      '{OP_CLEAR,  7'd0,   32'h0,         1'b1, '{ST_OK,    32'h0, 7'd0, 7'd0}},
      '{OP_INSERT, 7'd127, 32'h8000_0000, 1'b1, '{ST_RANGE, 32'h0, 7'd0, 7'd0}},
      '{OP_DELETE, 7'd127, 32'h0,         1'b1, '{ST_RANGE, 32'h0, 7'd0, 7'd0}}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (directed_rows[r]) begin
      send_word(directed_rows[r].op, directed_rows[r].position, directed_rows[r].value,
                predicted);
      pending_results.push_back(directed_rows[r].has_answer ? directed_rows[r].answer
                                                            : predicted);
    end

    // Random words in three idling phases; grow stretches are drawn longer than the others.
    mix_left = 0;
    mix = MIX_BALANCED;
    for (int phase = 0; phase < 3; phase++) begin
      drain_results();
      case (phase)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_WORDS / 3; n++) begin
        if (mix_left == 0) begin
          mix = op_mix_t'($urandom_range(0, 2));
          mix_left = (mix == MIX_GROW) ? $urandom_range(80, 140) : $urandom_range(30, 90);
        end
        mix_left--;
        pick_random_word(mix, op, position, value);
        send_word(op, position, value, predicted);
        pending_results.push_back(predicted);
        if ($urandom_range(0, 99) == 0) drain_results();
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("positional_ordered_list_test: PASS");
    end else begin
      $display("positional_ordered_list_test: FAIL");
    end
    $finish;
  end

endmodule
